FILE: hdl/nap_pkg.sv
// ----------------------------------------------------------------------------
// nap_pkg
// Shared types, character codes and digit-weight tables for the NMEA
// altitude field parser.
// ----------------------------------------------------------------------------
package nap_pkg;

    // Field and register widths
    localparam int BYTE_W      = 8;
    localparam int ALT_W       = 47;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = 5;
    localparam int LEN_W       = 8;
    localparam int LINE_W      = 8;
    localparam int COMMA_W     = 5;
    localparam int INT_DIG_W   = 4;
    localparam int FRAC_E5_W   = 17;
    localparam int M_TDATA_W   = 56;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // ASCII codes
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // Limits and reset values
    localparam logic [IDX_W-1:0]     IDX_RESET   = 5'd9;
    localparam logic [LEN_W-1:0]     LEN_RESET   = 8'd82;
    localparam logic [COMMA_W-1:0]   COMMA_SAT   = 5'd31;
    localparam logic [INT_DIG_W-1:0] INT_DIG_MAX = 4'd9;
    localparam logic [ALT_W-1:0]     INT_SCALE   = 47'd100000;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_IN     = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FIELD = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_t;

    // Register indexes (byte address / 4)
    typedef enum logic {
        REG_FIELD_IDX = 1'b0,
        REG_MAX_LEN   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0] field_comma_index;
        logic [LEN_W-1:0] max_line_length;
    } cfg_t;

    // Weight in 1e-5 units of the fraction digit at position pos (1 = tenths).
    // Positions past the fifth fall below the output resolution.
    function automatic logic [FRAC_E5_W-1:0] frac_weight(input int unsigned pos);
        logic [FRAC_E5_W-1:0] w;
        case (pos)
            1:       w = 17'd10000;
            2:       w = 17'd1000;
            3:       w = 17'd100;
            4:       w = 17'd10;
            5:       w = 17'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Integer digit value in 1e-5 units
    function automatic logic [ALT_W-1:0] digit_e5(input logic [3:0] d);
        return ALT_W'({{(ALT_W-4){1'b0}}, d} * INT_SCALE);
    endfunction

endpackage

FILE: hdl/nmea_altitude_field_parser.sv
// ----------------------------------------------------------------------------
// nmea_altitude_field_parser
// Streams GPS sentence text and reports the altitude field of each line.
// ----------------------------------------------------------------------------
// Takes one ASCII byte per clock on s_* and produces one word on m_* for each
// newline: the field that follows comma number field_comma_index, as an
// unsigned decimal in units of 1e-5, or a status of malformed field or line
// too long. Throughput is one byte per cycle; the only stall is a newline
// arriving while the previous result still sits unread in the result
// register. An accepted newline passes through the input register, then the
// parser and result register, before m_tvalid rises. Digits are folded into
// pre-scaled accumulators as they arrive, so the newline only needs one add.
// Registers sit at byte address 0 (field_comma_index, reset 9) and 4
// (max_line_length, reset 82); change them only while the stream is idle.
// ----------------------------------------------------------------------------
module nmea_altitude_field_parser #(
    parameter int MAX_FRACTION_DIGITS = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [nap_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [nap_pkg::M_TDATA_W-1:0]    m_tdata,   // [46:0] altitude_e5,
                                                        // [48:47] status, [55:49] 0
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nap_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [nap_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [nap_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    nap_pkg::cfg_t               cfg;
    logic                        byte_valid;
    logic [nap_pkg::BYTE_W-1:0]  byte_data;
    logic                        byte_take;

    nap_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nap_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    nap_parse #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // A consumed newline always shows up as a result word next cycle
    a_nl_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_take && byte_data == nap_pkg::CH_NL) |=> m_tvalid)
        else $error("newline consumed without result word");

    // A stalled result blocks the next newline
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(byte_take && byte_data == nap_pkg::CH_NL))
        else $error("result overwritten while stalled");

    // Altitude is zero unless status is ok
    a_alt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48:47] != nap_pkg::ST_OK) |-> (m_tdata[46:0] == '0))
        else $error("altitude nonzero with error status");

    // Status code three is never produced
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:47] != 2'd3))
        else $error("status out of range");

endmodule

FILE: hdl/nap_cfg.sv
// ----------------------------------------------------------------------------
// nap_cfg
// APB register file: comma index of the altitude field and line length limit.
// ----------------------------------------------------------------------------
module nap_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nap_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [nap_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [nap_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output nap_pkg::cfg_t                     cfg
);

    logic [nap_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [nap_pkg::LEN_W-1:0] len_reg, len_next;
    logic                      wr_en;
    nap_pkg::reg_idx_t         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = nap_pkg::reg_idx_t'(paddr[2]);

    // Write decode
    always_comb begin
        idx_next = idx_reg;
        len_next = len_reg;
        if (wr_en) begin
            unique case (reg_sel)
                nap_pkg::REG_FIELD_IDX: idx_next = pwdata[nap_pkg::IDX_W-1:0];
                nap_pkg::REG_MAX_LEN:   len_next = pwdata[nap_pkg::LEN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= nap_pkg::IDX_RESET;
            len_reg <= nap_pkg::LEN_RESET;
        end else begin
            idx_reg <= idx_next;
            len_reg <= len_next;
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            nap_pkg::REG_FIELD_IDX: prdata[nap_pkg::IDX_W-1:0] = idx_reg;
            nap_pkg::REG_MAX_LEN:   prdata[nap_pkg::LEN_W-1:0] = len_reg;
        endcase
    end

    assign cfg.field_comma_index = idx_reg;
    assign cfg.max_line_length   = len_reg;

endmodule

FILE: hdl/nap_in_stage.sv
// ----------------------------------------------------------------------------
// nap_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module nap_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nap_pkg::BYTE_W-1:0]    s_tdata,
    output logic                          byte_valid,
    output logic [nap_pkg::BYTE_W-1:0]    byte_data,
    input  logic                          byte_take
);

    logic                         valid_reg, valid_next;
    logic [nap_pkg::BYTE_W-1:0]   byte_reg, byte_next;

    // Free when empty or when the held word moves on this cycle
    assign s_tready = !valid_reg || byte_take;

    always_comb begin
        valid_next = valid_reg && !byte_take;
        byte_next  = byte_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            byte_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

FILE: hdl/nap_parse.sv
// ----------------------------------------------------------------------------
// nap_parse
// Per-line parser state and the result register. Each byte updates line
// length, comma count and the decimal accumulators; a newline loads a result.
// ----------------------------------------------------------------------------
module nap_parse #(
    parameter int MAX_FRACTION_DIGITS = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  nap_pkg::cfg_t                    cfg,
    input  logic                             byte_valid,
    input  logic [nap_pkg::BYTE_W-1:0]       byte_data,
    output logic                             byte_take,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [nap_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int FD_W = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam logic [FD_W-1:0] FD_MAX = FD_W'(MAX_FRACTION_DIGITS);

    // Per-line state
    logic [nap_pkg::LINE_W-1:0]     line_cnt_reg, line_cnt_next;
    logic [nap_pkg::COMMA_W-1:0]    comma_cnt_reg, comma_cnt_next;
    logic                           discard_reg, discard_next;
    nap_pkg::phase_t                phase_reg, phase_next;
    logic                           dot_reg, dot_next;
    logic [nap_pkg::ALT_W-1:0]      int_e5_reg, int_e5_next;
    logic [nap_pkg::FRAC_E5_W-1:0]  frac_e5_reg, frac_e5_next;
    logic [nap_pkg::INT_DIG_W-1:0]  int_dig_reg, int_dig_next;
    logic [FD_W-1:0]                frac_dig_reg, frac_dig_next;
    logic                           bad_reg, bad_next;

    // Result register
    logic                           out_valid_reg, out_valid_next;
    logic [nap_pkg::ALT_W-1:0]      alt_reg, alt_next;
    nap_pkg::status_t               status_reg, status_next;

    logic                           is_nl;
    logic                           is_digit;
    logic [3:0]                     digit;
    logic [nap_pkg::LINE_W:0]       len_sum;
    logic [nap_pkg::COMMA_W-1:0]    comma_inc;
    logic [nap_pkg::FRAC_E5_W-1:0]  frac_w;
    logic [nap_pkg::FRAC_E5_W-1:0]  frac_add;

    assign is_nl    = (byte_data == nap_pkg::CH_NL);
    assign is_digit = (byte_data >= nap_pkg::CH_ZERO) && (byte_data <= nap_pkg::CH_NINE);
    assign digit    = 4'(byte_data - nap_pkg::CH_ZERO);
    assign len_sum  = {1'b0, line_cnt_reg} + 9'd1;
    assign comma_inc = (comma_cnt_reg < nap_pkg::COMMA_SAT) ? comma_cnt_reg + 5'd1
                                                             : comma_cnt_reg;
    assign frac_w   = nap_pkg::frac_weight(32'(frac_dig_reg) + 32'd1);
    assign frac_add = nap_pkg::FRAC_E5_W'({13'b0, digit} * frac_w);

    // A newline needs the result slot; other bytes always move
    assign byte_take = byte_valid && (!is_nl || !out_valid_reg || m_tready);

    always_comb begin
        line_cnt_next  = line_cnt_reg;
        comma_cnt_next = comma_cnt_reg;
        discard_next   = discard_reg;
        phase_next     = phase_reg;
        dot_next       = dot_reg;
        int_e5_next    = int_e5_reg;
        frac_e5_next   = frac_e5_reg;
        int_dig_next   = int_dig_reg;
        frac_dig_next  = frac_dig_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        alt_next       = alt_reg;
        status_next    = status_reg;

        if (byte_take) begin
            if (is_nl) begin
                // Report the line, then clear all per-line state
                out_valid_next = 1'b1;
                alt_next       = '0;
                if (discard_reg) begin
                    status_next = nap_pkg::ST_TOO_LONG;
                end else if (phase_reg != nap_pkg::PH_DONE || bad_reg) begin
                    status_next = nap_pkg::ST_BAD_FIELD;
                end else begin
                    status_next = nap_pkg::ST_OK;
                    alt_next    = int_e5_reg + nap_pkg::ALT_W'(frac_e5_reg);
                end
                line_cnt_next  = '0;
                comma_cnt_next = '0;
                discard_next   = 1'b0;
                phase_next     = nap_pkg::PH_BEFORE;
                dot_next       = 1'b0;
                int_e5_next    = '0;
                frac_e5_next   = '0;
                int_dig_next   = '0;
                frac_dig_next  = '0;
                bad_next       = 1'b0;
            end else if (!discard_reg) begin
                if (len_sum >= {1'b0, cfg.max_line_length}) begin
                    discard_next = 1'b1;
                end else begin
                    line_cnt_next = line_cnt_reg + 8'd1;
                    case (phase_reg)
                        nap_pkg::PH_BEFORE: begin
                            // Look for the comma that opens the field
                            if (byte_data == nap_pkg::CH_COMMA) begin
                                comma_cnt_next = comma_inc;
                                if (comma_inc == cfg.field_comma_index) begin
                                    phase_next = nap_pkg::PH_IN;
                                end
                            end
                        end
                        nap_pkg::PH_IN: begin
                            if (is_digit) begin
                                if (!dot_reg) begin
                                    if (int_dig_reg >= nap_pkg::INT_DIG_MAX) begin
                                        bad_next   = 1'b1;
                                        phase_next = nap_pkg::PH_DONE;
                                    end else begin
                                        // x10 as shift-add, digit pre-scaled by 1e5
                                        int_e5_next  = (int_e5_reg << 3) + (int_e5_reg << 1)
                                                     + nap_pkg::digit_e5(digit);
                                        int_dig_next = int_dig_reg + 4'd1;
                                    end
                                end else begin
                                    if (frac_dig_reg >= FD_MAX) begin
                                        bad_next   = 1'b1;
                                        phase_next = nap_pkg::PH_DONE;
                                    end else begin
                                        frac_e5_next  = frac_e5_reg + frac_add;
                                        frac_dig_next = frac_dig_reg + FD_W'(1);
                                    end
                                end
                            end else if (byte_data == nap_pkg::CH_DOT) begin
                                dot_next = 1'b1;
                            end else begin
                                // Field terminator: only a comma after digits is clean
                                if (byte_data != nap_pkg::CH_COMMA ||
                                    (int_dig_reg == '0 && frac_dig_reg == '0)) begin
                                    bad_next = 1'b1;
                                end
                                phase_next = nap_pkg::PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_cnt_reg  <= '0;
            comma_cnt_reg <= '0;
            discard_reg   <= 1'b0;
            phase_reg     <= nap_pkg::PH_BEFORE;
            dot_reg       <= 1'b0;
            int_e5_reg    <= '0;
            frac_e5_reg   <= '0;
            int_dig_reg   <= '0;
            frac_dig_reg  <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            line_cnt_reg  <= line_cnt_next;
            comma_cnt_reg <= comma_cnt_next;
            discard_reg   <= discard_next;
            phase_reg     <= phase_next;
            dot_reg       <= dot_next;
            int_e5_reg    <= int_e5_next;
            frac_e5_reg   <= frac_e5_next;
            int_dig_reg   <= int_dig_next;
            frac_dig_reg  <= frac_dig_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        alt_reg    <= alt_next;
        status_reg <= status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, status_reg, alt_reg};

endmodule
